/* src/assert_macros.svh */
// ----------------------------------------------------------------------------
// assert_macros
// shared concurrent assertion macros for the echo block
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked on every rising edge of clk outside of reset
`define FDE_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// checked on every rising edge of clk, reset included
`define FDE_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* src/fde_pkg.sv */
// ----------------------------------------------------------------------------
// fde_pkg
// shared types, constants and helpers of the feedback delay echo
// ----------------------------------------------------------------------------
package fde_pkg;

  localparam int DELAY_DEPTH = 65536;
  localparam int DEPTH_AW    = $clog2(DELAY_DEPTH);
  localparam int DELAY_W     = 16;
  localparam int CMP_W       = (DEPTH_AW > DELAY_W) ? DEPTH_AW : DELAY_W;
  localparam int DELAY_MAX   = DELAY_DEPTH - 1;

  localparam int SW       = 24;
  localparam int GAIN_W   = 16;
  localparam int FB_W     = 15;
  localparam int PW       = SW + GAIN_W + 1;
  localparam int SCALED_W = PW - 15;
  localparam int SUM_W    = SCALED_W + 1;

  localparam int FB_MAX = 31129;
  localparam int UNITY  = 32768;

  localparam logic [1:0] REG_DELAY  = 2'd0;
  localparam logic [1:0] REG_FB     = 2'd1;
  localparam logic [1:0] REG_MIX    = 2'd2;
  localparam logic [1:0] REG_BYPASS = 2'd3;

  typedef struct packed {
    logic [DEPTH_AW-1:0] wa;
    logic [DEPTH_AW-1:0] ra;
    logic                fill;
  } ptr_t;

  typedef struct packed {
    logic                 valid;
    logic                 pass;
    logic                 last;
    logic signed [SW-1:0] x;
    ptr_t                 ptr;
  } stage_in_t;

  typedef struct packed {
    logic                we;
    logic [DEPTH_AW-1:0] addr;
    logic [SW-1:0]       data;
  } wr_t;

  typedef struct packed {
    logic          valid;
    logic          last;
    logic [SW-1:0] sample;
  } push_t;

  function automatic logic signed [SW-1:0] sat24(input logic signed [SUM_W-1:0] v);
    logic signed [SW-1:0] r;
    if (v > $signed(SUM_W'(8388607))) begin
      r = 24'sh7FFFFF;
    end else if (v < -$signed(SUM_W'(8388608))) begin
      r = 24'sh800000;
    end else begin
      r = v[SW-1:0];
    end
    return r;
  endfunction

endpackage

/* src/feedback_delay_echo.sv */
// ----------------------------------------------------------------------------
// feedback_delay_echo
// audio echo with a feedback delay line held in block ram
// ----------------------------------------------------------------------------
// channels: s_* carries input samples (tdata = in_sample, signed q1.23,
// tlast = last_of_block), m_* returns one sample per request, the mix or,
// with bypass or delay 0, the input (tdata = out_sample, tlast = block_end).
// cfg_we/cfg_addr/cfg_wdata write delay_samples (0), feedback_gain (1),
// mix_gain (2) and bypass (3); write them only while no request is in flight.
// throughput: one request per cycle while s_tready is high. order: ram read
// and multiply, then sum and saturate, then the output register with m_tvalid.
// a tap one sample back is forwarded from the sum stage into the multipliers,
// which sets the critical path.
// reset: registers return to delay 0, feedback 0, mix 0.5, bypass off; the
// write pointer returns to zero and entries not yet written since reset
// read as zero through fill tracking, so no clearing sweep is needed.
// stall: the output keeps one skid entry; once it fills, s_tready drops
// the next cycle and the whole pipeline holds until m_tready returns.
// ----------------------------------------------------------------------------
module feedback_delay_echo import fde_pkg::*; (
  input  logic          clk,
  input  logic          rst,
  input  logic          cfg_we,
  input  logic [1:0]    cfg_addr,
  input  logic [15:0]   cfg_wdata,
  input  logic          s_tvalid,
  output logic          s_tready,
  input  logic [SW-1:0] s_tdata,   // [23:0] in_sample
  input  logic          s_tlast,
  output logic          m_tvalid,
  input  logic          m_tready,
  output logic [SW-1:0] m_tdata,   // [23:0] out_sample
  output logic          m_tlast
);

  logic [DELAY_W-1:0] delay_samples;
  logic [FB_W-1:0]    feedback_gain;
  logic [GAIN_W-1:0]  mix_gain;
  logic               bypass;

  logic      adv;
  logic      accept;
  logic      active;
  ptr_t      req;
  stage_in_t din;
  wr_t       wr;
  push_t     push;
  logic [SW-1:0] rdata;

  always_ff @(posedge clk) begin
    if (rst) begin
      delay_samples <= '0;
      feedback_gain <= '0;
      mix_gain      <= GAIN_W'(16384);
      bypass        <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        REG_DELAY:  delay_samples <= cfg_wdata[DELAY_W-1:0];
        REG_FB:     feedback_gain <= cfg_wdata[FB_W-1:0];
        REG_MIX:    mix_gain      <= cfg_wdata[GAIN_W-1:0];
        REG_BYPASS: bypass        <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  assign s_tready = adv;
  assign accept   = s_tvalid && adv;
  assign active   = !bypass && (delay_samples != '0);

  always_comb begin
    din.valid = accept;
    din.pass  = !active;
    din.last  = s_tlast;
    din.x     = s_tdata;
    din.ptr   = req;
  end

  fde_ptr u_ptr (
    .clk           (clk),
    .rst           (rst),
    .step          (accept && active),
    .delay_samples (delay_samples),
    .req           (req)
  );

  fde_ram #(
    .DEPTH (DELAY_DEPTH),
    .WIDTH (SW),
    .AW    (DEPTH_AW)
  ) u_ram (
    .clk   (clk),
    .we    (wr.we),
    .waddr (wr.addr),
    .wdata (wr.data),
    .re    (accept && active),
    .raddr (req.ra),
    .rdata (rdata)
  );

  fde_mac u_mac (
    .clk           (clk),
    .rst           (rst),
    .adv           (adv),
    .din           (din),
    .rdata         (rdata),
    .feedback_gain (feedback_gain),
    .mix_gain      (mix_gain),
    .wr            (wr),
    .push          (push)
  );

  fde_obuf u_obuf (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .adv      (adv),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

endmodule

/* src/fde_ram.sv */
// ----------------------------------------------------------------------------
// fde_ram
// simple dual-port ram, one write and one registered read port
// ----------------------------------------------------------------------------
module fde_ram #(
  parameter int DEPTH = 65536,
  parameter int WIDTH = 24,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* src/fde_ptr.sv */
// ----------------------------------------------------------------------------
// fde_ptr
// write pointer, tap address and fill tracking of the delay line
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module fde_ptr import fde_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               step,
  input  logic [DELAY_W-1:0] delay_samples,
  output ptr_t               req
);

  logic [DEPTH_AW-1:0] wp;
  logic                wrapped;
  logic [DEPTH_AW-1:0] dc;
  logic [DEPTH_AW:0]   diff;
  logic [DEPTH_AW-1:0] ra;

  always_comb begin
    if (CMP_W'(delay_samples) > CMP_W'(DELAY_MAX)) begin
      dc = DEPTH_AW'(DELAY_MAX);
    end else begin
      dc = DEPTH_AW'(delay_samples);
    end
    diff = {1'b0, wp} - {1'b0, dc};
    if (diff[DEPTH_AW]) begin
      ra = DEPTH_AW'(diff + (DEPTH_AW + 1)'(DELAY_DEPTH));
    end else begin
      ra = diff[DEPTH_AW-1:0];
    end
    req.wa   = wp;
    req.ra   = ra;
    req.fill = wrapped || (ra < wp);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp      <= '0;
      wrapped <= 1'b0;
    end else if (step) begin
      if (wp == DEPTH_AW'(DELAY_MAX)) begin
        wp      <= '0;
        wrapped <= 1'b1;
      end else begin
        wp <= wp + 1'b1;
      end
    end
  end

  `FDE_ASSERT(a_tap_not_head, step |-> req.ra != req.wa, "tap address equals write pointer")
  `FDE_ASSERT(a_ptr_moves, step |=> wp != $past(wp), "write pointer did not move")

endmodule

/* src/fde_mac.sv */
// ----------------------------------------------------------------------------
// fde_mac
// tap select with forwarding, gain multiplies, mix and feedback sums
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module fde_mac import fde_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              adv,
  input  stage_in_t         din,
  input  logic [SW-1:0]     rdata,
  input  logic [FB_W-1:0]   feedback_gain,
  input  logic [GAIN_W-1:0] mix_gain,
  output wr_t               wr,
  output push_t             push
);

  // stage a: read data arrives
  logic                 a_valid;
  logic                 a_pass;
  logic                 a_last;
  logic signed [SW-1:0] a_x;
  ptr_t                 a_ptr;

  // stage b: registered products
  logic                 b_valid;
  logic                 b_pass;
  logic                 b_last;
  logic signed [SW-1:0] b_x;
  logic [DEPTH_AW-1:0]  b_wa;
  logic signed [PW-1:0] b_pdry;
  logic signed [PW-1:0] b_pwet;
  logic signed [PW-1:0] b_pfb;

  // last completed write
  logic                lw_valid;
  logic [DEPTH_AW-1:0] lw_addr;
  logic [SW-1:0]       lw_data;

  logic [GAIN_W-1:0]       wet;
  logic [GAIN_W-1:0]       dry;
  logic [FB_W-1:0]         fb;
  logic signed [SW-1:0]    delayed;
  logic signed [PW-1:0]    p_dry;
  logic signed [PW-1:0]    p_wet;
  logic signed [PW-1:0]    p_fb;
  logic signed [SCALED_W-1:0] s_dry;
  logic signed [SCALED_W-1:0] s_wet;
  logic signed [SCALED_W-1:0] s_fb;
  logic signed [SUM_W-1:0] mix_sum;
  logic signed [SUM_W-1:0] store_sum;
  logic signed [SW-1:0]    b_store;
  logic signed [SW-1:0]    b_out;

  always_comb begin
    wet = (mix_gain > GAIN_W'(UNITY)) ? GAIN_W'(UNITY) : mix_gain;
    dry = GAIN_W'(UNITY) - wet;
    fb  = (feedback_gain > FB_W'(FB_MAX)) ? FB_W'(FB_MAX) : feedback_gain;
  end

  // stage b sums, also forwarded to stage a
  always_comb begin
    s_dry     = b_pdry[PW-1:15];
    s_wet     = b_pwet[PW-1:15];
    s_fb      = b_pfb[PW-1:15];
    mix_sum   = {s_dry[SCALED_W-1], s_dry} + {s_wet[SCALED_W-1], s_wet};
    store_sum = {{(SUM_W-SW){b_x[SW-1]}}, b_x} + {s_fb[SCALED_W-1], s_fb};
    b_store   = sat24(store_sum);
    b_out     = b_pass ? b_x : sat24(mix_sum);
  end

  always_comb begin
    if (b_valid && !b_pass && (b_wa == a_ptr.ra)) begin
      delayed = b_store;
    end else if (lw_valid && (lw_addr == a_ptr.ra)) begin
      delayed = lw_data;
    end else if (a_ptr.fill) begin
      delayed = rdata;
    end else begin
      delayed = '0;
    end
    p_dry = $signed({1'b0, dry}) * a_x;
    p_wet = $signed({1'b0, wet}) * delayed;
    p_fb  = $signed({2'b00, fb}) * delayed;
  end

  always_comb begin
    wr.we       = adv && b_valid && !b_pass;
    wr.addr     = b_wa;
    wr.data     = b_store;
    push.valid  = adv && b_valid;
    push.last   = b_last;
    push.sample = b_out;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid  <= 1'b0;
      b_valid  <= 1'b0;
      lw_valid <= 1'b0;
    end else begin
      if (adv) begin
        a_valid <= din.valid;
        b_valid <= a_valid;
      end
      if (wr.we) begin
        lw_valid <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      a_pass <= din.pass;
      a_last <= din.last;
      a_x    <= din.x;
      a_ptr  <= din.ptr;
      b_pass <= a_pass;
      b_last <= a_last;
      b_x    <= a_x;
      b_wa   <= a_ptr.wa;
      b_pdry <= p_dry;
      b_pwet <= p_wet;
      b_pfb  <= p_fb;
    end
    if (wr.we) begin
      lw_addr <= wr.addr;
      lw_data <= wr.data;
    end
  end

  `FDE_ASSERT(a_wet_moves_on, a_valid && !a_pass && adv |=> b_valid && !b_pass, "wet item lost")
  `FDE_ASSERT(a_stall_holds, !adv |=> $stable(b_valid) && $stable(b_wa), "stage b moved in stall")

endmodule

/* src/fde_obuf.sv */
// ----------------------------------------------------------------------------
// fde_obuf
// output register with skid entry, registered ready toward the pipeline
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module fde_obuf import fde_pkg::*; (
  input  logic          clk,
  input  logic          rst,
  input  push_t         push,
  output logic          adv,
  output logic          m_tvalid,
  input  logic          m_tready,
  output logic [SW-1:0] m_tdata,
  output logic          m_tlast
);

  logic          skid_valid;
  logic [SW-1:0] skid_data;
  logic          skid_last;

  assign adv = !skid_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid   <= 1'b0;
      skid_valid <= 1'b0;
    end else if (m_tready || !m_tvalid) begin
      if (skid_valid) begin
        m_tvalid   <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        m_tvalid <= push.valid;
      end
    end else if (push.valid) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (m_tready || !m_tvalid) begin
      if (skid_valid) begin
        m_tdata <= skid_data;
        m_tlast <= skid_last;
      end else begin
        m_tdata <= push.sample;
        m_tlast <= push.last;
      end
    end else if (push.valid) begin
      skid_data <= push.sample;
      skid_last <= push.last;
    end
  end

  `FDE_ASSERT_ALWAYS(a_skid_behind_out, skid_valid |-> m_tvalid, "skid holds data, output empty")

endmodule
